// File: rtl/ntpc_pkg.sv
// ----------------------------------------------------------------------------
// ntpc_pkg
// Shared types, constants and tables of the pursuit controller.
// ----------------------------------------------------------------------------
`default_nettype none
package ntpc_pkg;

  localparam int FRAC_BITS_DEF = 12;
  localparam int CORDIC_ITERS  = 24;
  localparam int ZW            = 34;   // angle accumulator width, Q30 signed
  localparam int CW            = 40;   // CORDIC x/y width
  localparam int SQW           = 33;   // squared distance width
  localparam int DW            = 36;   // square root working width

  localparam logic [1:0] KIND_POSE  = 2'd0;
  localparam logic [1:0] KIND_ENTRY = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;
  localparam logic [1:0] KIND_TICK  = 2'd3;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_LGAIN  = 2'd1;
  localparam logic [1:0] REG_AGAIN  = 2'd2;

  localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;

  // Arctangent of 2^-i in Q30.
  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:  r = 34'sd843314857;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043837;
      5'd3:  r = 34'sd133525159;
      5'd4:  r = 34'sd67021687;
      5'd5:  r = 34'sd33543516;
      5'd6:  r = 34'sd16775851;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194283;
      5'd9:  r = 34'sd2097149;
      default: r = (i < 5'd24) ? (ZW'(34'sd1) <<< (5'd30 - i)) : '0;
    endcase
    return r;
  endfunction

  // Controller to datapath commands.
  typedef struct packed {
    logic load;     // capture input item operands
    logic sq;       // compute squared distance of item or goal
    logic entry;    // apply target entry update
    logic pose;     // store pose
    logic init;     // start sqrt and CORDIC
    logic iter;     // one iteration step
    logic fin1;     // finish: bearing round, products
    logic fin2;     // finish: build result
  } ntpc_cmd_t;

  typedef struct packed {
    logic goal_ok;   // list seen and goal valid
    logic reached;   // distance at or below radius
  } ntpc_stat_t;

endpackage
`default_nettype wire

// File: rtl/ntpc_if.sv
// ----------------------------------------------------------------------------
// ntpc_in_if / ntpc_out_if
// Valid/ready channels of the pursuit controller.
// ----------------------------------------------------------------------------
`default_nettype none
interface ntpc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [15:0]        x_pos;
  logic [15:0]        y_pos;
  logic signed [14:0] heading;
  logic [7:0]         target_id;
  logic               last_entry;
  modport source (output valid, kind, x_pos, y_pos, heading, target_id, last_entry,
                  input ready);
  modport sink   (input valid, kind, x_pos, y_pos, heading, target_id, last_entry,
                  output ready);
endinterface

interface ntpc_out_if;
  logic               valid;
  logic               ready;
  logic [19:0]        linear_speed;
  logic signed [18:0] angular_speed;
  logic               catch_flag;
  logic [7:0]         catch_id;
  modport source (output valid, linear_speed, angular_speed, catch_flag, catch_id,
                  input ready);
  modport sink   (input valid, linear_speed, angular_speed, catch_flag, catch_id,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/ntpc_datapath.sv
// ----------------------------------------------------------------------------
// ntpc_datapath
// Pose and goal state, squared distance, bit-serial square root, CORDIC
// vectoring and output scaling.
// ----------------------------------------------------------------------------
`default_nettype none
module ntpc_datapath
  import ntpc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ntpc_cmd_t          cmd,
  output ntpc_stat_t              stat,
  input  wire logic [1:0]         kind,
  input  wire logic [15:0]        x_pos,
  input  wire logic [15:0]        y_pos,
  input  wire logic signed [14:0] heading,
  input  wire logic [7:0]         target_id,
  input  wire logic               last_entry,
  input  wire logic [15:0]        catch_radius,
  input  wire logic [11:0]        linear_gain,
  input  wire logic [11:0]        angular_gain,
  output logic [19:0]             linear_speed,
  output logic signed [18:0]      angular_speed,
  output logic                    catch_flag,
  output logic [7:0]              catch_id
);

  localparam logic signed [ZW-1:0] RND = ZW'(34'sd1) <<< (29 - FRAC_BITS);
  localparam logic signed [ZW-1:0] PI_F = (PI_Q30 + RND) >>> (30 - FRAC_BITS);

  // Architectural state.
  logic [15:0]        own_x, own_y, goal_x, goal_y, best_x, best_y;
  logic signed [14:0] own_heading;
  logic               list_seen, goal_valid;
  logic [7:0]         goal_id, best_id;
  logic [SQW-1:0]     best_dist_sq;

  // Working registers.
  logic [15:0]        op_x, op_y;
  logic [7:0]         op_id;
  logic               op_last;
  logic signed [16:0] dx, dy;
  logic [SQW-1:0]     dsq;
  logic [SQW-1:0]     rem;      // sqrt remainder operand
  logic [DW-1:0]      root;     // partial root, scaled by the current bit
  logic [35:0]        sbit;
  logic signed [CW-1:0] cx, cy;
  logic signed [ZW-1:0] cz;
  logic [4:0]         it;
  logic signed [ZW-1:0] err;
  logic [31:0]        lin_p;
  logic signed [35:0] ang_p;
  logic signed [35:0] ang_shift;

  logic signed [33:0] dx2, dy2;
  assign dx2 = dx * dx;
  assign dy2 = dy * dy;

  assign stat.goal_ok = list_seen & goal_valid;
  assign stat.reached = (root <= DW'(catch_radius));

  // Sqrt step: one result bit per iteration (two bits of operand).
  logic [35:0] rsum;
  assign rsum = root + sbit;

  // CORDIC step.
  logic signed [CW-1:0] sx, sy;
  assign sx = cx >>> it;
  assign sy = cy >>> it;

  // Bearing rounding and wrap.
  logic signed [ZW-1:0] bear, e0;
  assign bear = (cz + RND) >>> (30 - FRAC_BITS);
  assign e0 = bear - ZW'(own_heading);

  // Turn rate product and scaling.
  assign ang_p = 36'(err) * $signed({24'd0, angular_gain});
  assign ang_shift = ang_p >>> 8;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_x <= '0; own_y <= '0; own_heading <= '0;
      list_seen <= 1'b0; goal_valid <= 1'b0;
      goal_x <= '0; goal_y <= '0; goal_id <= '0;
      best_dist_sq <= '1; best_x <= '0; best_y <= '0; best_id <= '0;
    end else begin
      if (cmd.load) begin
        op_x <= x_pos; op_y <= y_pos; op_id <= target_id; op_last <= last_entry;
        if (kind == KIND_TICK) begin
          dx <= $signed({1'b0, goal_x}) - $signed({1'b0, own_x});
          dy <= $signed({1'b0, goal_y}) - $signed({1'b0, own_y});
        end else begin
          dx <= $signed({1'b0, x_pos}) - $signed({1'b0, own_x});
          dy <= $signed({1'b0, y_pos}) - $signed({1'b0, own_y});
        end
        if (kind == KIND_EMPTY) list_seen <= 1'b1;
      end
      if (cmd.pose) begin
        own_x <= x_pos; own_y <= y_pos; own_heading <= heading;
      end
      if (cmd.sq) dsq <= SQW'(dx2) + SQW'(dy2);
      if (cmd.entry) begin
        if (op_last) begin
          goal_valid <= 1'b1; list_seen <= 1'b1; best_dist_sq <= '1;
          if (dsq < best_dist_sq) begin
            goal_x <= op_x; goal_y <= op_y; goal_id <= op_id;
            best_x <= op_x; best_y <= op_y; best_id <= op_id;
          end else begin
            goal_x <= best_x; goal_y <= best_y; goal_id <= best_id;
          end
        end else if (dsq < best_dist_sq) begin
          best_dist_sq <= dsq; best_x <= op_x; best_y <= op_y; best_id <= op_id;
        end
      end
      // Start sqrt and CORDIC with the left half plane folded.
      if (cmd.init) begin
        rem  <= SQW'(dx2) + SQW'(dy2);
        root <= '0;
        sbit <= 36'h1_0000_0000;
        it   <= '0;
        if (dx < 0) begin
          cz <= (dy < 0) ? -PI_Q30 : PI_Q30;
          cx <= CW'(-dx) <<< 20;
          cy <= CW'(-dy) <<< 20;
        end else begin
          cz <= '0;
          cx <= CW'(dx) <<< 20;
          cy <= CW'(dy) <<< 20;
        end
      end
      if (cmd.iter) begin
        // The root is complete once the operand bit has shifted out.
        if (sbit != '0) begin
          if ({3'd0, rem} >= rsum) begin
            rem  <= rem - SQW'(rsum);
            root <= (root >> 1) + sbit;
          end else begin
            root <= root >> 1;
          end
          sbit <= sbit >> 2;
        end
        if (cy > 0) begin
          cx <= cx + sy; cy <= cy - sx; cz <= cz + atan_q30(it);
        end else begin
          cx <= cx - sy; cy <= cy + sx; cz <= cz - atan_q30(it);
        end
        it <= it + 5'd1;
      end
      if (cmd.fin1) begin
        if (dx == 0 && dy == 0) err <= -ZW'(own_heading);
        else if (e0 > PI_F) err <= e0 - 2 * PI_F;
        else if (e0 < -PI_F) err <= e0 + 2 * PI_F;
        else err <= e0;
        lin_p <= 32'(root) * 32'(linear_gain);
      end
      if (cmd.fin2) begin
        if (stat.reached) begin
          linear_speed <= '0; angular_speed <= '0;
          catch_flag <= 1'b1; catch_id <= goal_id;
          goal_valid <= 1'b0;
        end else begin
          linear_speed <= (lin_p[31:8] > 24'd1048575) ? 20'hFFFFF : lin_p[27:8];
          if (ang_shift > 36'sd262143) angular_speed <= 19'sd262143;
          else if (ang_shift < -36'sd262144) angular_speed <= -19'sd262144;
          else angular_speed <= ang_shift[18:0];
          catch_flag <= 1'b0; catch_id <= '0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/ntpc_ctrl.sv
// ----------------------------------------------------------------------------
// ntpc_ctrl
// Sequencer: accepts items, steps the datapath, presents results.
// ----------------------------------------------------------------------------
`default_nettype none
module ntpc_ctrl
  import ntpc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] kind,
  output logic            out_valid,
  input  wire logic       out_ready,
  output ntpc_cmd_t       cmd,
  input  wire ntpc_stat_t stat
);

  typedef enum logic [2:0] {S_IDLE, S_SQ, S_ENTRY, S_ITER, S_FIN1, S_FIN2, S_OUT} state_t;
  state_t     state;
  logic [4:0] cnt;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // Commands decoded from state.
  always_comb begin
    cmd = '0;
    cmd.load = in_valid && in_ready;
    cmd.pose = cmd.load && (kind == KIND_POSE);
    unique case (state)
      S_SQ:    cmd.sq = 1'b1;
      S_ENTRY: cmd.entry = 1'b1;
      S_ITER:  cmd.iter = 1'b1;
      S_FIN1:  cmd.fin1 = 1'b1;
      S_FIN2:  cmd.fin2 = 1'b1;
      default: ;
    endcase
    if (state == S_SQ && cnt == 5'd1) cmd.init = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          if (kind == KIND_ENTRY) begin
            state <= S_SQ; cnt <= 5'd0;
          end else if (kind == KIND_TICK && stat.goal_ok) begin
            state <= S_SQ; cnt <= 5'd1;
          end
        end
        S_SQ:    state <= (cnt == 5'd1) ? S_ITER : S_ENTRY;
        S_ENTRY: state <= S_IDLE;
        S_ITER: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd24) state <= S_FIN1;
        end
        S_FIN1:  state <= S_FIN2;
        S_FIN2:  state <= S_OUT;
        S_OUT:   if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/nearest_target_pursuit_controller_core.sv
// ----------------------------------------------------------------------------
// nearest_target_pursuit_controller_core
// Nearest-target selection and proportional go-to-goal control.
// ----------------------------------------------------------------------------
// channel   direction  payload
// in        sink       kind, x_pos, y_pos, heading, target_id, last_entry
// out       source     linear_speed, angular_speed, catch_flag, catch_id
// cfg       APB        catch_radius, linear_gain, angular_gain
//
// Pose, empty-list and goal-less tick items are handled in S_IDLE alone; target
// entries pass S_SQ and S_ENTRY. A tick with a goal runs operand setup, 24 CORDIC
// steps that also step the square root until done, S_FIN1, S_FIN2 and S_OUT.
// A result waits in the output register until taken; reset is synchronous.
// ----------------------------------------------------------------------------
`default_nettype none
module nearest_target_pursuit_controller_core
  import ntpc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  ntpc_in_if.sink          in_ch,
  ntpc_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [15:0] catch_radius;
  logic [11:0] linear_gain, angular_gain;
  ntpc_cmd_t   cmd;
  ntpc_stat_t  stat;

  assign pready = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      catch_radius <= 16'd2048;
      linear_gain  <= 12'd512;
      angular_gain <= 12'd1536;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (paddr[3:2])
        REG_RADIUS: catch_radius <= pwdata[15:0];
        REG_LGAIN:  linear_gain  <= pwdata[11:0];
        REG_AGAIN:  angular_gain <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (paddr[3:2])
      REG_RADIUS: prdata = {16'd0, catch_radius};
      REG_LGAIN:  prdata = {20'd0, linear_gain};
      REG_AGAIN:  prdata = {20'd0, angular_gain};
      default:    prdata = '0;
    endcase
  end

  ntpc_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready), .kind (in_ch.kind),
    .out_valid (out_ch.valid), .out_ready (out_ch.ready),
    .cmd, .stat
  );

  ntpc_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst, .cmd, .stat,
    .kind (in_ch.kind), .x_pos (in_ch.x_pos), .y_pos (in_ch.y_pos),
    .heading (in_ch.heading), .target_id (in_ch.target_id),
    .last_entry (in_ch.last_entry),
    .catch_radius, .linear_gain, .angular_gain,
    .linear_speed (out_ch.linear_speed), .angular_speed (out_ch.angular_speed),
    .catch_flag (out_ch.catch_flag), .catch_id (out_ch.catch_id)
  );

endmodule
`default_nettype wire
